FILE: rtl/i2cm_pkg.sv
// shared types, codes and constants of the i2c master bit engine
package i2cm_pkg;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
    localparam int          BYTE_BITS       = 8;
    localparam int          QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       ack_received;
        logic [7:0] rx_byte;
        logic       rejected;
    } t_out_item;

    typedef enum logic [2:0] {
        K_TICK  = 3'd0,
        K_START = 3'd1,
        K_STOP  = 3'd2,
        K_WRITE = 3'd3,
        K_READ  = 3'd4
    } t_kind;

    // request after decode, as it travels from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } t_cmd;

endpackage

FILE: rtl/i2cm_front.sv
// front end: accepts requests, decodes the request type and registers them
module i2cm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  i2cm_pkg::t_in_item i_in_item,
    output logic            o_push,
    output i2cm_pkg::t_cmd  o_cmd,
    input  logic            i_q_ready
);
    import i2cm_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;

    always_comb begin
        n_cmd.tx_byte     = i_in_item.tx_byte;
        n_cmd.ack_to_send = i_in_item.ack_to_send;
        n_cmd.sda_in      = i_in_item.sda_in;
        unique case (i_in_item.req_type)
            REQ_START: n_cmd.kind = K_START;
            REQ_STOP:  n_cmd.kind = K_STOP;
            REQ_WRITE: n_cmd.kind = K_WRITE;
            REQ_READ:  n_cmd.kind = K_READ;
            // tick and the unused codes
            default:   n_cmd.kind = K_TICK;
        endcase
    end

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_push     = r_valid && i_q_ready;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: rtl/i2cm_queue.sv
// short request queue between front and back
module i2cm_queue #(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  i2cm_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output i2cm_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import i2cm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = r_count < CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!do_push && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/i2cm_back.sv
// back end: line sequencer, phase timer and result register
module i2cm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_q_valid,
    input  i2cm_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output i2cm_pkg::t_out_item o_out_item
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_STOP  = 5'b00100,
        S_WRITE = 5'b01000,
        S_READ  = 5'b10000
    } t_mode;

    localparam logic [3:0] NBITS = 4'(BYTE_BITS);

    logic [15:0] r_phase_ticks;
    t_mode       r_mode,       n_mode;
    logic [1:0]  r_step,       n_step;
    logic [3:0]  r_bit,        n_bit;
    logic [15:0] r_wait,       n_wait;
    logic [7:0]  r_shift,      n_shift;
    logic        r_scl,        n_scl;
    logic        r_sda,        n_sda;
    logic        r_ack_flag,   n_ack_flag;
    logic        r_ack_choice, n_ack_choice;
    logic [7:0]  r_rx_hold,    n_rx_hold;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic        enter;
    logic        done;
    logic        rej;
    logic        is_cmd;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign is_cmd      = i_cmd.kind != K_TICK;

    always_comb begin
        n_mode       = r_mode;
        n_step       = r_step;
        n_bit        = r_bit;
        n_wait       = r_wait;
        n_shift      = r_shift;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack_flag   = r_ack_flag;
        n_ack_choice = r_ack_choice;
        n_rx_hold    = r_rx_hold;
        enter        = 1'b0;
        done         = 1'b0;
        rej          = 1'b0;

        if (is_cmd && r_mode != S_IDLE) begin
            rej = 1'b1;
        end else if (is_cmd) begin
            n_bit  = '0;
            n_step = 2'd0;
            enter  = 1'b1;
            unique case (i_cmd.kind)
                K_START: n_mode = S_START;
                K_STOP:  n_mode = S_STOP;
                K_WRITE: begin
                    n_mode     = S_WRITE;
                    n_shift    = i_cmd.tx_byte;
                    n_ack_flag = 1'b0;
                end
                default: begin
                    n_mode       = S_READ;
                    n_shift      = '0;
                    n_ack_choice = i_cmd.ack_to_send;
                    n_step       = 2'd1;
                end
            endcase
        end else if (r_mode != S_IDLE) begin
            if (r_wait > 16'd1) begin
                n_wait = r_wait - 16'd1;
            end else begin
                n_wait = '0;
                // end of phase: sample or shift
                if (r_mode == S_WRITE) begin
                    if (r_step == 2'd1 && r_bit == NBITS) begin
                        n_ack_flag = !i_cmd.sda_in;
                    end
                    if (r_step == 2'd2 && r_bit < NBITS) begin
                        n_shift = {r_shift[6:0], 1'b0};
                    end
                end else if (r_mode == S_READ) begin
                    if (r_step == 2'd1 && r_bit < NBITS) begin
                        n_shift = {r_shift[6:0], i_cmd.sda_in};
                    end
                end
                if (r_step < 2'd2) begin
                    n_step = r_step + 2'd1;
                    enter  = 1'b1;
                end else if (r_mode == S_START || r_mode == S_STOP || r_bit >= NBITS) begin
                    if (r_mode == S_READ) begin
                        n_rx_hold = n_shift;
                    end
                    n_mode = S_IDLE;
                    n_step = 2'd0;
                    n_bit  = '0;
                    done   = 1'b1;
                end else begin
                    n_bit  = r_bit + 4'd1;
                    n_step = (r_mode == S_READ && n_bit < NBITS) ? 2'd1 : 2'd0;
                    enter  = 1'b1;
                end
            end
        end

        if (enter) begin
            unique case (n_mode)
                S_START: begin
                    if (n_step == 2'd0) begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                    end else if (n_step == 2'd1) begin
                        n_sda = 1'b0;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                S_STOP: begin
                    if (n_step == 2'd0) begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                    end else if (n_step == 2'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b1;
                    end
                end
                S_WRITE: begin
                    if (n_step == 2'd0) begin
                        // ack slot releases sda
                        n_sda = (n_bit < NBITS) ? n_shift[7] : 1'b1;
                    end else if (n_step == 2'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                S_READ: begin
                    if (n_step == 2'd0) begin
                        n_sda = !n_ack_choice;
                    end else if (n_step == 2'd1) begin
                        n_scl = 1'b1;
                        if (n_bit < NBITS) begin
                            n_sda = 1'b1;
                        end
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            n_wait = (r_phase_ticks == '0) ? 16'd1 : r_phase_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_mode        <= S_IDLE;
            r_step        <= '0;
            r_bit         <= '0;
            r_wait        <= '0;
            r_shift       <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_ack_flag    <= 1'b0;
            r_ack_choice  <= 1'b0;
            r_rx_hold     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_phase_ticks <= i_cfg_data;
            end
            if (o_pop) begin
                r_mode       <= n_mode;
                r_step       <= n_step;
                r_bit        <= n_bit;
                r_wait       <= n_wait;
                r_shift      <= n_shift;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_ack_flag   <= n_ack_flag;
                r_ack_choice <= n_ack_choice;
                r_rx_hold    <= n_rx_hold;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item.scl_level    <= n_scl;
            r_out_item.sda_level    <= n_sda;
            r_out_item.busy_res     <= n_mode != S_IDLE;
            r_out_item.done_res     <= done;
            r_out_item.ack_received <= n_ack_flag;
            r_out_item.rx_byte      <= n_rx_hold;
            r_out_item.rejected     <= rej;
        end
    end

endmodule

FILE: rtl/i2c_master_bit_engine_unit.sv
// top level of the i2c master bit engine
//
// Each request on the input channel is a tick carrying the sampled SDA
// level or a command (start, stop, write byte, read byte); codes 5 to 7
// act as ticks. Every request gives exactly one result on the output
// channel with the SCL/SDA drive levels, busy, done, ack and read byte.
// A command that arrives while a sequence runs is dropped and flagged as
// rejected. Each line phase lasts phase_ticks ticks (one tick if it is
// zero), set through the config channel (the user writes it only while
// idle, which the block does not enforce; always ready; reset value 100).
// Throughput is one request per cycle while the receiver does not stall:
// the sequencer updates its full state once for each request it takes.
// From input accept to output valid, the front register takes the
// request, the queue stores it and the result register loads its result.
// When the receiver stalls, the result register holds, the queue fills
// and then the input side stops accepting. Reset is synchronous, active
// low; it empties the queue, releases both lines and reloads phase_ticks.
module i2c_master_bit_engine_unit #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  i2cm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output i2cm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    import i2cm_pkg::*;

    logic push;
    logic q_ready;
    logic q_valid;
    logic pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    i2cm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_push     (push),
        .o_cmd      (f_cmd),
        .i_q_ready  (q_ready)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    i2cm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: rtl/i2cm_checker.sv
// port-level checks of the i2c master bit engine, bound to the top level
module i2cm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input i2cm_pkg::t_out_item o_out_item
);
    import i2cm_pkg::*;

    // a result waiting for the receiver is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a finishing sequence leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |-> !o_out_item.busy_res)
        else $error("done with busy still set");

    // a rejected request only happens while busy and ends nothing
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.rejected |->
            o_out_item.busy_res && !o_out_item.done_res)
        else $error("reject outside a running sequence");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
